/* rtl/ltlw_pkg.sv */
// ----------------------------------------------------------------------------
// ltlw_pkg
// Types, codes and character tables shared by the text line writer and its
// checker.
// ----------------------------------------------------------------------------
package ltlw_pkg;

    // operation codes of an input item
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE  = 1'b1;

    // control characters and fixed byte values
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] BAD_GLYPH = 8'hCD;
    localparam logic [7:0] BOM_0     = 8'hEF;
    localparam logic [7:0] BOM_1     = 8'hBB;
    localparam logic [7:0] BOM_2     = 8'hBF;
    localparam logic [8:0] CYR_PAGE  = 9'h008;   // code points 0x0400..0x047f
    localparam logic [7:0] LINE_BASE_RST = 8'h80;

    // payload of an input item
    typedef struct packed {
        logic       opcode;
        logic [7:0] char_byte;
        logic [5:0] new_column;
    } in_item_t;

    // payload of a result item
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_value;
        logic       last;
    } out_item_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCROLL_CMD,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_SCROLL_PAD,
        ST_PUT_CMD,
        ST_PUT_DATA,
        ST_CLEAR_CMD,
        ST_CLEAR_DATA
    } seq_state_t;

    // ascii to panel charset, zero means unmapped
    localparam logic [7:0] ASCII_MAP [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5a, 8'h5b, 8'h04, 8'h5d, 8'h5e, 8'h5f,
        8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7a, 8'h05, 8'hd1, 8'h06, 8'he9, 8'hff
    };

    // cyrillic block to panel charset, zero means unmapped
    localparam logic [7:0] CYR_MAP [0:127] = '{
        8'h00, 8'ha2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
        8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
        8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
        8'hac, 8'he2, 8'had, 8'hae, 8'h07, 8'haf, 8'hb0, 8'hb1,
        8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
        8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
        8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
        8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
        8'h00, 8'hb5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // code point to panel glyph
    function automatic logic [7:0] map_code(input logic [15:0] cp);
        logic [7:0] g;
        g = 8'h00;
        if (cp[15:7] == 9'h000) begin
            g = ASCII_MAP[cp[6:0]];
        end else if (cp[15:7] == CYR_PAGE) begin
            g = CYR_MAP[cp[6:0]];
        end
        return (g == 8'h00) ? BAD_GLYPH : g;
    endfunction

endpackage

/* rtl/lcd_text_line_writer_core.sv */
// ----------------------------------------------------------------------------
// lcd_text_line_writer_core
// Keeps the text of one character display line and turns character items
// into the command and data bytes of the display controller.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per character byte (opcode put) or cursor move.
//   m_ channel: command bytes (is_data 0) and data bytes (is_data 1); the
//     last byte caused by an item carries last.
//   cfg_ port: writes line_base and raw_mode; the user writes only while the block is idle (not enforced by the block).
// Timing:
//   one item at a time. A move, line feed, carriage return or a pending
//   UTF-8 byte emits no byte. A plain character emits 2 bytes. A form feed
//   emits COLUMNS+1 bytes at one per cycle unless the receiver stalls. A
//   write on a full line scrolls: the row memory is read and written back
//   one entry at a time through its registered read port.
//   Results go through one output register; while the receiver stalls the
//   sequencer holds, and the next item is taken while the last byte waits.
// Reset:
//   cursor at column 0, no pending UTF-8 bytes, line_base 0x80, raw_mode 0,
//   the row reads as spaces at once (one valid bit per column).
// ----------------------------------------------------------------------------
module lcd_text_line_writer_core #(
    parameter int unsigned COLUMNS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [ltlw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_wdata,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ltlw_pkg::in_item_t                 s_item,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output ltlw_pkg::out_item_t                m_item
);

    localparam int unsigned IDX_W = $clog2(COLUMNS);
    localparam int unsigned CUR_W = $clog2(COLUMNS + 1);
    localparam logic [CUR_W-1:0] COL_END  = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0] COL_LAST = CUR_W'(COLUMNS - 1);

    // registers
    ltlw_pkg::seq_state_t state_reg, state_next;
    ltlw_pkg::in_item_t   item_reg, item_next;
    ltlw_pkg::out_item_t  out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CUR_W-1:0]     cursor_reg, cursor_next;
    logic [CUR_W-1:0]     scan_reg, scan_next;
    logic [7:0]           lead_reg, lead_next;
    logic [7:0]           second_reg, second_next;
    logic [7:0]           glyph_reg, glyph_next;
    logic [7:0]           line_base_reg;
    logic                 raw_reg;
    logic [COLUMNS-1:0]   valid_reg;

    // row memory
    logic [7:0]           row_mem [COLUMNS];
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [7:0]           mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic                 clear_all;
    logic [7:0]           rd_byte;

    // decoder results
    logic [7:0]           dec_char;
    logic [15:0]          dec_cp;
    logic                 dec_emit;
    logic [7:0]           dec_lead;
    logic [7:0]           dec_second;
    logic [7:0]           dec_glyph;

    logic                 slot_free;

    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;
    assign slot_free = !out_valid_reg || m_ready;
    assign rd_byte   = rd_valid_reg ? rd_data_reg : ltlw_pkg::CH_SPACE;

    // tab to space, then utf-8 decode and charset mapping of the held byte (raw mode passes it through)
    always_comb begin
        dec_char   = (item_reg.char_byte == ltlw_pkg::CH_TAB) ? ltlw_pkg::CH_SPACE
                                                              : item_reg.char_byte;
        dec_cp     = {8'h00, dec_char};
        dec_emit   = 1'b1;
        dec_lead   = lead_reg;
        dec_second = second_reg;
        if (!raw_reg) begin
            if (!dec_char[7]) begin
                dec_lead   = 8'h00;
                dec_second = 8'h00;
            end else if (lead_reg == 8'h00) begin
                dec_lead = dec_char;
                dec_emit = 1'b0;
            end else if (second_reg == 8'h00) begin
                if (lead_reg[5]) begin
                    dec_second = dec_char;
                    dec_emit   = 1'b0;
                end else begin
                    dec_cp   = {5'b00000, lead_reg[4:0], dec_char[5:0]};
                    dec_lead = 8'h00;
                end
            end else begin
                dec_cp     = {lead_reg[3:0], second_reg[5:0], dec_char[5:0]};
                dec_lead   = 8'h00;
                dec_second = 8'h00;
                if (lead_reg == ltlw_pkg::BOM_0 && second_reg == ltlw_pkg::BOM_1 &&
                    dec_char == ltlw_pkg::BOM_2) begin
                    dec_emit = 1'b0;
                end
            end
            dec_glyph = ltlw_pkg::map_code(dec_cp);
        end else begin
            dec_glyph = dec_char;
        end
    end

    // sequencer next state and outputs
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cursor_next    = cursor_reg;
        scan_next      = scan_reg;
        lead_next      = lead_reg;
        second_next    = second_reg;
        glyph_next     = glyph_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        clear_all      = 1'b0;
        s_ready        = 1'b0;

        case (state_reg)
            ltlw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = ltlw_pkg::ST_EVAL;
                end
            end
            ltlw_pkg::ST_EVAL: begin
                state_next = ltlw_pkg::ST_IDLE;
                if (item_reg.opcode == ltlw_pkg::OP_MOVE) begin
                    if ({1'b0, item_reg.new_column} < 7'(COLUMNS)) begin
                        cursor_next = CUR_W'(item_reg.new_column);
                    end
                end else begin
                    case (item_reg.char_byte)
                        ltlw_pkg::CH_LF: begin
                            state_next = ltlw_pkg::ST_IDLE;
                        end
                        ltlw_pkg::CH_CR: begin
                            cursor_next = '0;
                        end
                        ltlw_pkg::CH_FF: begin
                            clear_all   = 1'b1;
                            cursor_next = '0;
                            lead_next   = 8'h00;
                            second_next = 8'h00;
                            state_next  = ltlw_pkg::ST_CLEAR_CMD;
                        end
                        default: begin
                            lead_next   = dec_lead;
                            second_next = dec_second;
                            if (dec_emit) begin
                                glyph_next = dec_glyph;
                                state_next = (cursor_reg >= COL_END) ?
                                             ltlw_pkg::ST_SCROLL_CMD : ltlw_pkg::ST_PUT_CMD;
                            end
                        end
                    endcase
                end
            end
            // full line: address the line, then shift the row left
            ltlw_pkg::ST_SCROLL_CMD: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b0, bus_value: line_base_reg, last: 1'b0};
                    scan_next      = CUR_W'(1);
                    state_next     = ltlw_pkg::ST_SCROLL_RD;
                end
            end
            ltlw_pkg::ST_SCROLL_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = scan_reg[IDX_W-1:0];
                state_next = ltlw_pkg::ST_SCROLL_WR;
            end
            ltlw_pkg::ST_SCROLL_WR: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b1, bus_value: rd_byte, last: 1'b0};
                    mem_we         = 1'b1;
                    mem_waddr      = IDX_W'(scan_reg - CUR_W'(1));
                    mem_wdata      = rd_byte;
                    scan_next      = scan_reg + CUR_W'(1);
                    state_next     = (scan_reg == COL_LAST) ? ltlw_pkg::ST_SCROLL_PAD
                                                            : ltlw_pkg::ST_SCROLL_RD;
                end
            end
            ltlw_pkg::ST_SCROLL_PAD: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b1, bus_value: ltlw_pkg::CH_SPACE,
                                       last: 1'b0};
                    cursor_next    = COL_LAST;
                    state_next     = ltlw_pkg::ST_PUT_CMD;
                end
            end
            // set address, then the character itself
            ltlw_pkg::ST_PUT_CMD: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b0,
                                       bus_value: line_base_reg | 8'(cursor_reg),
                                       last: 1'b0};
                    state_next     = ltlw_pkg::ST_PUT_DATA;
                end
            end
            ltlw_pkg::ST_PUT_DATA: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b1, bus_value: glyph_reg, last: 1'b1};
                    mem_we         = 1'b1;
                    mem_waddr      = cursor_reg[IDX_W-1:0];
                    mem_wdata      = glyph_reg;
                    cursor_next    = cursor_reg + CUR_W'(1);
                    state_next     = ltlw_pkg::ST_IDLE;
                end
            end
            // form feed: address the line and blank every column
            ltlw_pkg::ST_CLEAR_CMD: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b0, bus_value: line_base_reg, last: 1'b0};
                    scan_next      = '0;
                    state_next     = ltlw_pkg::ST_CLEAR_DATA;
                end
            end
            ltlw_pkg::ST_CLEAR_DATA: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_data: 1'b1, bus_value: ltlw_pkg::CH_SPACE,
                                       last: (scan_reg == COL_LAST)};
                    scan_next      = scan_reg + CUR_W'(1);
                    if (scan_reg == COL_LAST) begin
                        state_next = ltlw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ltlw_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ltlw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
            lead_reg      <= 8'h00;
            second_reg    <= 8'h00;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cursor_reg    <= cursor_next;
            lead_reg      <= lead_next;
            second_reg    <= second_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        out_reg   <= out_next;
        scan_reg  <= scan_next;
        glyph_reg <= glyph_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_base_reg <= ltlw_pkg::LINE_BASE_RST;
            raw_reg       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                ltlw_pkg::REG_LINE_BASE: line_base_reg <= cfg_wdata;
                ltlw_pkg::REG_RAW_MODE:  raw_reg       <= cfg_wdata[0];
                default: begin
                    raw_reg <= raw_reg;
                end
            endcase
        end
    end

    // column valid bits: a column not yet written reads as a space
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear_all) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // row memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg  <= row_mem[mem_raddr];
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

endmodule

/* rtl/ltlw_checker.sv */
// ----------------------------------------------------------------------------
// ltlw_checker
// Port-level checks of the text line writer, bound to lcd_text_line_writer_core.
// ----------------------------------------------------------------------------
module ltlw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ltlw_pkg::out_item_t m_item
);

    // a stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result item changed");

    // one input item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // no input is taken while a byte sequence is still unfinished
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last |-> !s_ready)
        else $error("input ready in the middle of a byte sequence");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lcd_text_line_writer_core ltlw_checker u_ltlw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the text line writer against its own model of the row text, the
// cursor and the UTF-8 decoder. A short table of directed items comes first,
// then random phases under different line_base and raw_mode settings. Both
// channels stall at random, and every result byte is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS       = 16;
    localparam int SETTLE_CYCLES = 2 * COLUMNS + 16;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 57;

    // one directed item, with the address and glyph typed in where obvious
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [5:0] col;
        logic       known;
        logic [7:0] cmd_byte;
        logic [7:0] glyph;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{ltlw_pkg::OP_PUT,  8'h41, 6'd0,  1'b1, 8'h80, 8'h41},   // first char after reset
        '{ltlw_pkg::OP_MOVE, 8'h00, 6'd63, 1'b0, 8'h00, 8'h00},   // move out of range
        '{ltlw_pkg::OP_MOVE, 8'h00, 6'd15, 1'b0, 8'h00, 8'h00},   // last column
        '{ltlw_pkg::OP_PUT,  8'h7F, 6'd0,  1'b1, 8'h8F, 8'hFF},   // highest ascii code
        '{ltlw_pkg::OP_PUT,  8'h00, 6'd0,  1'b0, 8'h00, 8'h00},   // full line, unmapped
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::CH_LF, 6'd0, 1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::CH_CR, 6'd0, 1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::CH_TAB, 6'd0, 1'b1, 8'h80, ltlw_pkg::CH_SPACE},
        '{ltlw_pkg::OP_PUT,  8'hD0, 6'd0,  1'b0, 8'h00, 8'h00},   // cyrillic lead
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::CH_LF, 6'd0, 1'b0, 8'h00, 8'h00}, // mid sequence
        '{ltlw_pkg::OP_PUT,  8'h90, 6'd0,  1'b1, 8'h81, 8'h41},
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::BOM_0, 6'd0, 1'b0, 8'h00, 8'h00}, // byte-order mark
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::BOM_1, 6'd0, 1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::BOM_2, 6'd0, 1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  8'hE2, 6'd0,  1'b0, 8'h00, 8'h00},   // three bytes, unmapped
        '{ltlw_pkg::OP_PUT,  8'h82, 6'd0,  1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  8'hAC, 6'd0,  1'b1, 8'h82, ltlw_pkg::BAD_GLYPH},
        '{ltlw_pkg::OP_PUT,  8'hC3, 6'd0,  1'b0, 8'h00, 8'h00},   // lead aborted by ascii
        '{ltlw_pkg::OP_PUT,  8'h41, 6'd0,  1'b1, 8'h83, 8'h41},
        '{ltlw_pkg::OP_PUT,  8'hD1, 6'd0,  1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  8'h91, 6'd0,  1'b1, 8'h84, 8'hB5},
        '{ltlw_pkg::OP_PUT,  8'hFF, 6'd0,  1'b0, 8'h00, 8'h00},   // top lead acts as 3-byte
        '{ltlw_pkg::OP_PUT,  8'h80, 6'd0,  1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  8'h80, 6'd0,  1'b1, 8'h85, ltlw_pkg::BAD_GLYPH},
        '{ltlw_pkg::OP_PUT,  8'hD0, 6'd0,  1'b0, 8'h00, 8'h00},   // form feed drops lead
        '{ltlw_pkg::OP_PUT,  ltlw_pkg::CH_FF, 6'd0, 1'b0, 8'h00, 8'h00},
        '{ltlw_pkg::OP_PUT,  8'h5C, 6'd0,  1'b1, 8'h80, 8'h04}
    };

    // register settings of the random phases
    localparam logic [7:0] PHASE_BASE [0:PHASES-1] = '{8'hC0, 8'h00, 8'hFF, 8'h00, 8'h80};
    localparam logic       PHASE_RAW  [0:PHASES-1] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [ltlw_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [7:0]                          cfg_wdata = '0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    ltlw_pkg::in_item_t                  s_item    = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    ltlw_pkg::out_item_t                 m_item;

    // model state of the line
    logic [7:0]  base_cmd;
    logic        raw_on;
    logic [7:0]  row_text [0:COLUMNS-1];
    int          cursor_col;
    logic [7:0]  utf_lead;
    logic [7:0]  utf_second;

    ltlw_pkg::out_item_t   item_bytes[$];      // bytes caused by the item just taken
    ltlw_pkg::out_item_t   bus_bytes_due[$];   // bytes still owed by the block
    ltlw_pkg::in_item_t    plan_q[$];
    int          plan_count;
    int          mismatch_count = 0;
    bit          send_calm = 1'b0;

    lcd_text_line_writer_core #(
        .COLUMNS (COLUMNS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic ltlw_pkg::out_item_t bus_byte(logic is_data, logic [7:0] value);
        ltlw_pkg::out_item_t b;
        b.is_data   = is_data;
        b.bus_value = value;
        b.last      = 1'b0;
        return b;
    endfunction

    // code point to panel glyph, unmapped codes give the bad glyph
    function automatic logic [7:0] glyph_of(logic [15:0] cp);
        logic [7:0] g;
        g = 8'h00;
        if (cp < 16'h0080) begin
            g = ltlw_pkg::ASCII_MAP[cp[6:0]];
        end else if ((cp >> 7) == 16'(ltlw_pkg::CYR_PAGE)) begin
            g = ltlw_pkg::CYR_MAP[cp[6:0]];
        end
        return (g == 8'h00) ? ltlw_pkg::BAD_GLYPH : g;
    endfunction

    task automatic line_reset();
        base_cmd   = ltlw_pkg::LINE_BASE_RST;
        raw_on     = 1'b0;
        cursor_col = 0;
        utf_lead   = 8'h00;
        utf_second = 8'h00;
        for (int i = 0; i < COLUMNS; i++) row_text[i] = ltlw_pkg::CH_SPACE;
    endtask

    // mark the final byte of the item
    task automatic close_item();
        ltlw_pkg::out_item_t b;
        b = item_bytes.pop_back();
        b.last = 1'b1;
        item_bytes.push_back(b);
    endtask

    // works out the bytes that one item causes and updates the line state
    task automatic line_item(input ltlw_pkg::in_item_t it);
        logic [7:0]  c;
        logic [15:0] cp;
        item_bytes.delete();
        if (it.opcode == ltlw_pkg::OP_MOVE) begin
            if (it.new_column < COLUMNS) cursor_col = it.new_column;
            return;
        end
        c = it.char_byte;
        if (c == ltlw_pkg::CH_LF) return;
        if (c == ltlw_pkg::CH_CR) begin
            cursor_col = 0;
            return;
        end
        // form feed blanks the row and drops pending bytes
        if (c == ltlw_pkg::CH_FF) begin
            item_bytes.push_back(bus_byte(1'b0, base_cmd));
            for (int i = 0; i < COLUMNS; i++) begin
                item_bytes.push_back(bus_byte(1'b1, ltlw_pkg::CH_SPACE));
                row_text[i] = ltlw_pkg::CH_SPACE;
            end
            cursor_col = 0;
            utf_lead   = 8'h00;
            utf_second = 8'h00;
            close_item();
            return;
        end
        if (c == ltlw_pkg::CH_TAB) c = ltlw_pkg::CH_SPACE;

        // utf-8 decode and charset mapping
        if (!raw_on) begin
            if (!c[7]) begin
                utf_lead   = 8'h00;
                utf_second = 8'h00;
                cp = {8'h00, c};
            end else if (utf_lead == 8'h00) begin
                utf_lead = c;
                return;
            end else if (utf_second == 8'h00) begin
                if (utf_lead[5]) begin
                    utf_second = c;
                    return;
                end
                cp = {5'b0, utf_lead[4:0], c[5:0]};
                utf_lead = 8'h00;
            end else begin
                if (utf_lead == ltlw_pkg::BOM_0 && utf_second == ltlw_pkg::BOM_1 &&
                    c == ltlw_pkg::BOM_2) begin
                    utf_lead   = 8'h00;
                    utf_second = 8'h00;
                    return;
                end
                cp = {utf_lead[3:0], utf_second[5:0], c[5:0]};
                utf_lead   = 8'h00;
                utf_second = 8'h00;
            end
            c = glyph_of(cp);
        end

        // full line scrolls left by one
        if (cursor_col >= COLUMNS) begin
            item_bytes.push_back(bus_byte(1'b0, base_cmd));
            for (int i = 1; i < COLUMNS; i++) begin
                item_bytes.push_back(bus_byte(1'b1, row_text[i]));
                row_text[i-1] = row_text[i];
            end
            item_bytes.push_back(bus_byte(1'b1, ltlw_pkg::CH_SPACE));
            cursor_col = COLUMNS - 1;
        end
        item_bytes.push_back(bus_byte(1'b0, base_cmd | 8'(cursor_col)));
        item_bytes.push_back(bus_byte(1'b1, c));
        row_text[cursor_col] = c;
        cursor_col++;
        close_item();
    endtask

    // sender gap, mostly short with calm stretches
    function automatic int sender_gap();
        int r;
        if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
        if (send_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // drive one item from a falling edge, wait for it to be taken
    task automatic send_item(input ltlw_pkg::in_item_t it, input logic known,
                             input logic [7:0] cmd_byte, input logic [7:0] glyph,
                             input int idle);
        ltlw_pkg::out_item_t b;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        line_item(it);
        if (known) begin
            b = bus_byte(1'b1, glyph);
            b.last = 1'b1;
            bus_bytes_due.push_back(bus_byte(1'b0, cmd_byte));
            bus_bytes_due.push_back(b);
        end else begin
            foreach (item_bytes[i]) bus_bytes_due.push_back(item_bytes[i]);
        end
        @(negedge aclk);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (bus_bytes_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // both registers, back to back, block idle
    task automatic write_regs(input logic [7:0] base, input logic raw);
        cfg_we    <= 1'b1;
        cfg_index <= ltlw_pkg::REG_LINE_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_index <= ltlw_pkg::REG_RAW_MODE;
        cfg_wdata <= {7'b0, raw};
        @(negedge aclk);
        cfg_we    <= 1'b0;
        base_cmd = base;
        raw_on   = raw;
    endtask

    function automatic ltlw_pkg::in_item_t put_item(logic [7:0] b);
        ltlw_pkg::in_item_t it;
        it.opcode     = ltlw_pkg::OP_PUT;
        it.char_byte  = b;
        it.new_column = 6'($urandom_range(0, 63));
        return it;
    endfunction

    task automatic plan_put(input logic [7:0] b);
        plan_q.push_back(put_item(b));
        plan_count++;
    endtask

    task automatic plan_move(input logic [5:0] col);
        ltlw_pkg::in_item_t it;
        it.opcode     = ltlw_pkg::OP_MOVE;
        it.char_byte  = 8'($urandom_range(0, 255));
        it.new_column = col;
        plan_q.push_back(it);
        plan_count++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one short sequence of random items, mostly well formed
    task automatic plan_burst();
        int r;
        logic [7:0] lead;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            plan_put(8'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 45) begin
            plan_put(8'($urandom_range(8'h00, 8'h7F)));
        end else if (r < 55) begin
            plan_put($urandom_range(0, 1) ? 8'hD1 : 8'hD0);
            plan_put(cont_byte());
        end else if (r < 62) begin
            plan_put(8'($urandom_range(8'hC0, 8'hDF)));
            plan_put(cont_byte());
        end else if (r < 70) begin
            plan_put(8'($urandom_range(8'hE0, 8'hEF)));
            plan_put(cont_byte());
            plan_put(cont_byte());
        end else if (r < 73) begin
            plan_put(ltlw_pkg::BOM_0);
            plan_put(ltlw_pkg::BOM_1);
            plan_put(ltlw_pkg::BOM_2);
        end else if (r < 78) begin
            plan_move(6'($urandom_range(0, COLUMNS - 1)));
        end else if (r < 80) begin
            plan_move(6'($urandom_range(COLUMNS, 63)));
        end else if (r < 83) begin
            plan_put(ltlw_pkg::CH_CR);
        end else if (r < 85) begin
            plan_put(ltlw_pkg::CH_TAB);
        end else if (r < 87) begin
            plan_put(ltlw_pkg::CH_LF);
        end else if (r < 89) begin
            plan_put(ltlw_pkg::CH_FF);
        end else if (r < 95) begin
            plan_put(8'($urandom_range(0, 255)));
        end else begin
            // broken sequence: cut short by an ascii byte
            lead = 8'($urandom_range(8'hC0, 8'hFF));
            plan_put(lead);
            if (lead[5] && $urandom_range(0, 1)) plan_put(cont_byte());
            plan_put(8'($urandom_range(8'h00, 8'h7F)));
        end
    endtask

    // result side stalls
    initial begin
        int  stall;
        int  r;
        bit  calm;
        calm = 1'b0;
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            if ($urandom_range(0, 19) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            if (calm || r < 50) stall = 0;
            else if (r < 85) stall = $urandom_range(1, 3);
            else if (r < 96) stall = $urandom_range(4, 10);
            else stall = $urandom_range(15, 30);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // compare each result byte with the oldest one owed
    always @(posedge aclk) begin
        ltlw_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bus_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte, expected none, %s is_data=%0b value=%h last=%0b",
                         $realtime, "actual", m_item.is_data, m_item.bus_value,
                         m_item.last);
                mismatch_count++;
            end else begin
                want = bus_bytes_due.pop_front();
                if (m_item.is_data !== want.is_data) begin
                    $display("%0t: is_data mismatch, expected %0b actual %0b",
                             $realtime, want.is_data, m_item.is_data);
                    mismatch_count++;
                end
                if (m_item.bus_value !== want.bus_value) begin
                    $display("%0t: bus_value mismatch, expected %h actual %h",
                             $realtime, want.bus_value, m_item.bus_value);
                    mismatch_count++;
                end
                if (m_item.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $realtime, want.last, m_item.last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        ltlw_pkg::in_item_t  it;
        dir_row_t  row;
        int        idle;
        bit        hold;
        logic [7:0] base;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        line_reset();

        // directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            row = DIRECTED[k];
            it.opcode     = row.op;
            it.char_byte  = row.ch;
            it.new_column = row.col;
            idle = (k == DIR_ROWS - 1) ? 1 : sender_gap();
            send_item(it, row.known, row.cmd_byte, row.glyph, idle);
        end

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            base = (ph == 3) ? 8'($urandom_range(0, 255)) : PHASE_BASE[ph];
            write_regs(base, PHASE_RAW[ph]);
            plan_q.delete();
            plan_count = 0;
            while (plan_count < PHASE_ITEMS) plan_burst();
            for (int k = 0; k < plan_q.size(); k++) begin
                idle = sender_gap();
                // now and then hold the sender until the line is drained
                hold = (k == plan_q.size() / 2) || ($urandom_range(0, 39) == 0);
                if ((hold || k == plan_q.size() - 1) && idle == 0) idle = 1;
                send_item(plan_q[k], 1'b0, 8'h00, 8'h00, idle);
                if (hold) begin
                    while (bus_bytes_due.size() != 0) @(negedge aclk);
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/ltlw_pkg.sv
rtl/lcd_text_line_writer_core.sv
rtl/ltlw_checker.sv
dv/testbench.sv
